### design/glf_pkg.sv
package glf_pkg;

  localparam int MaxWidth   = 2048;
  localparam int LineBufs   = 4;
  localparam int AddrW      = $clog2(MaxWidth);
  localparam int SlotW      = $clog2(LineBufs);
  localparam int PixW       = 8;
  localparam int ColW       = 11;
  localparam int RowW       = 12;
  localparam int CfgDataW   = 12;
  localparam int CfgIdxW    = 1;
  localparam int WinN       = 5;

  localparam logic [CfgIdxW-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT = 1'd1;

  localparam logic [CfgDataW-1:0] WidthReset  = 12'd640;
  localparam logic [CfgDataW-1:0] HeightReset = 12'd480;
  localparam logic [CfgDataW-1:0] MinSize     = 12'd5;
  localparam logic [CfgDataW-1:0] MaxWidthW   = CfgDataW'(MaxWidth);

  localparam int GreyW = 18;
  localparam logic [9:0] RedWt   = 10'd307;
  localparam logic [9:0] GreenWt = 10'd604;
  localparam logic [9:0] BlueWt  = 10'd113;
  localparam int GreyShift = 10;

  localparam logic [7:0] ClampMax = 8'd255;

  typedef logic [PixW-1:0] pix_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [SlotW-1:0] slot;
    logic [ColW-1:0]  column;
    logic [RowW-1:0]  row;
    logic             frame_end;
    logic             produce;
  } pos_t;

  function automatic pix_t grey_of(input pix_t r, input pix_t g, input pix_t b);
    logic [GreyW-1:0] sum;
    sum = GreyW'(r) * GreyW'(RedWt) + GreyW'(g) * GreyW'(GreenWt)
        + GreyW'(b) * GreyW'(BlueWt);
    return sum[GreyShift +: PixW];
  endfunction

endpackage

### design/glf_pix_if.sv
interface glf_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### design/glf_res_if.sv
interface glf_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  edge_value;
  logic [10:0] column;
  logic [11:0] row;
  logic        frame_end;

  modport source (output valid, output edge_value, output column, output row,
                  output frame_end, input ready);
  modport sink   (input valid, input edge_value, input column, input row,
                  input frame_end, output ready);
endinterface

### design/grey_log5x5_filter_top.sv
// Grey conversion and 5x5 Laplacian-of-Gaussian edge filter.
// pix_i takes one RGB pixel per beat in raster order; each pixel is turned
// into grey and written into a four-line store while a 5x5 window slides
// along the current row. res_o gives one beat for every pixel whose window
// centre lies two or more pixels from each edge: the clamped response, the
// centre column and the vertically flipped row; frame_end marks the last one.
// cfg_we_i/cfg_idx_i/cfg_data_i write image_width (0) and image_height (1);
// write them only between frames while nothing is in flight.
// Throughput is one pixel per cycle while res_o is not stalled. A pixel passes
// the registered stages grey and line store read, window shift, kernel and clamp.
// The line store has four banks; each accepted pixel reads all four and writes one.
// Reset clears counters, window and pipeline valids and loads 640x480; the
// line store is not cleared and no clearing pass runs.
// When res_o stalls, the result is held and up to two further pixels are
// accepted into empty pipeline stages before pix_i.ready drops.
module grey_log5x5_filter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  glf_pix_if.sink                        pix_i,
  glf_res_if.source                      res_o,
  input  logic                           cfg_we_i,
  input  logic [glf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [glf_pkg::CfgDataW-1:0]   cfg_data_i
);
  import glf_pkg::*;

  logic [CfgDataW-1:0] width_q, height_q;
  logic accept, out_en, s2_en, s1_en;
  pos_t pos;
  pix_t grey;
  pix_t line_rd [LineBufs];
  pix_t score;

  logic s1_valid_q, s2_valid_q, out_valid_q;
  pos_t s1_pos_q, s2_pos_q;
  pix_t s1_grey_q;
  pix_t out_edge_q;
  logic [ColW-1:0] out_col_q;
  logic [RowW-1:0] out_row_q;
  logic out_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_en      = !out_valid_q || res_o.ready;
  assign s2_en       = !s2_valid_q || out_en;
  assign s1_en       = !s1_valid_q || s2_en;
  assign pix_i.ready = s1_en;
  assign accept      = pix_i.valid && s1_en;

  assign grey = grey_of(pix_i.red, pix_i.green, pix_i.blue);

  glf_pos u_pos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (accept),
    .width_i  (width_q),
    .height_i (height_q),
    .pos_o    (pos)
  );

  glf_line_buf u_line_buf (
    .clk_i     (clk_i),
    .en_i      (accept),
    .addr_i    (pos.addr),
    .wr_slot_i (pos.slot),
    .wdata_i   (grey),
    .rdata_o   (line_rd)
  );

  glf_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s2_en && s1_valid_q),
    .line_i  (line_rd),
    .slot_i  (s1_pos_q.slot),
    .grey_i  (s1_grey_q),
    .score_o (score)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= pix_i.valid;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_en) begin
        out_valid_q <= s2_valid_q && s2_pos_q.produce;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pos_q  <= pos;
      s1_grey_q <= grey;
    end
    if (s2_en && s1_valid_q) begin
      s2_pos_q <= s1_pos_q;
    end
    if (out_en && s2_valid_q) begin
      out_edge_q <= score;
      out_col_q  <= s2_pos_q.column;
      out_row_q  <= s2_pos_q.row;
      out_end_q  <= s2_pos_q.frame_end;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.edge_value = out_edge_q;
  assign res_o.column     = out_col_q;
  assign res_o.row        = out_row_q;
  assign res_o.frame_end  = out_end_q;
endmodule

### design/glf_pos.sv
module glf_pos (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  logic [glf_pkg::CfgDataW-1:0]   width_i,
  input  logic [glf_pkg::CfgDataW-1:0]   height_i,
  output glf_pkg::pos_t                  pos_o
);
  import glf_pkg::*;

  logic [ColW-1:0]     col_q, col_d;
  logic [RowW-1:0]     row_q, row_d;
  logic [CfgDataW-1:0] w_eff, h_eff;
  logic [ColW-1:0]     c0;
  logic [RowW-1:0]     r_pre, r0, rn;
  logic [ColW:0]       cn;

  always_comb begin
    if (width_i < MinSize) begin
      w_eff = MinSize;
    end else if (width_i > MaxWidthW) begin
      w_eff = MaxWidthW;
    end else begin
      w_eff = width_i;
    end
    h_eff = (height_i < MinSize) ? MinSize : height_i;

    if ({1'b0, col_q} >= w_eff) begin
      c0    = '0;
      r_pre = row_q + 12'd1;
    end else begin
      c0    = col_q;
      r_pre = row_q;
    end
    r0 = (r_pre >= h_eff) ? '0 : r_pre;

    cn = {1'b0, c0} + 12'd1;
    rn = r0 + 12'd1;
    if (cn >= w_eff) begin
      col_d = '0;
      row_d = (rn >= h_eff) ? '0 : rn;
    end else begin
      col_d = cn[ColW-1:0];
      row_d = r0;
    end

    pos_o.addr      = c0[AddrW-1:0];
    pos_o.slot      = r0[SlotW-1:0];
    pos_o.column    = c0 - 11'd2;
    pos_o.row       = h_eff + 12'd1 - r0;
    pos_o.frame_end = (r0 == h_eff - 12'd1) && ({1'b0, c0} == w_eff - 12'd1);
    pos_o.produce   = (r0 >= 12'd4) && (c0 >= 11'd4);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (adv_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end
endmodule

### design/glf_line_buf.sv
module glf_line_buf (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [glf_pkg::AddrW-1:0]     addr_i,
  input  logic [glf_pkg::SlotW-1:0]     wr_slot_i,
  input  glf_pkg::pix_t                 wdata_i,
  output glf_pkg::pix_t                 rdata_o [glf_pkg::LineBufs]
);
  import glf_pkg::*;

  pix_t bank_mem [LineBufs][MaxWidth];
  pix_t rd_q [LineBufs];

  for (genvar b = 0; b < LineBufs; b++) begin : g_bank
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rd_q[b] <= bank_mem[b][addr_i];
        if (wr_slot_i == SlotW'(b)) begin
          bank_mem[b][addr_i] <= wdata_i;
        end
      end
    end
    assign rdata_o[b] = rd_q[b];
  end
endmodule

### design/glf_window.sv
module glf_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        shift_i,
  input  glf_pkg::pix_t               line_i [glf_pkg::LineBufs],
  input  logic [glf_pkg::SlotW-1:0]   slot_i,
  input  glf_pkg::pix_t               grey_i,
  output glf_pkg::pix_t               score_o
);
  import glf_pkg::*;

  pix_t win_q [WinN][WinN];
  logic [11:0] centre, neg, diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int y = 0; y < WinN; y++) begin
        for (int x = 0; x < WinN; x++) begin
          win_q[y][x] <= '0;
        end
      end
    end else if (shift_i) begin
      for (int y = 0; y < WinN; y++) begin
        for (int x = 0; x < WinN - 1; x++) begin
          win_q[y][x] <= win_q[y][x+1];
        end
      end
      for (int y = 0; y < WinN - 1; y++) begin
        win_q[y][WinN-1] <= line_i[slot_i + SlotW'(y)];
      end
      win_q[WinN-1][WinN-1] <= grey_i;
    end
  end

  always_comb begin
    centre = {win_q[2][2], 4'b0000};
    neg = 12'(win_q[1][1]) + 12'(win_q[1][3]) + 12'(win_q[3][1]) + 12'(win_q[3][3])
        + {3'b000, win_q[1][2], 1'b0} + {3'b000, win_q[2][1], 1'b0}
        + {3'b000, win_q[2][3], 1'b0} + {3'b000, win_q[3][2], 1'b0}
        + 12'(win_q[0][2]) + 12'(win_q[2][0]) + 12'(win_q[2][4]) + 12'(win_q[4][2]);
    diff = centre - neg;
    if (neg >= centre) begin
      score_o = '0;
    end else if (diff > 12'(ClampMax)) begin
      score_o = ClampMax;
    end else begin
      score_o = diff[PixW-1:0];
    end
  end
endmodule

### design/glf_chk.sv
module glf_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pix_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [7:0]  res_edge_i,
  input logic [10:0] res_column_i,
  input logic [11:0] res_row_i,
  input logic        res_end_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_edge_i)
      && $stable(res_column_i) && $stable(res_row_i) && $stable(res_end_i))
    else $error("result beat changed while stalled");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_valid_i && !res_ready_i) |-> pix_ready_i)
    else $error("input stalled while output is free");

  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_column_i >= 11'd2 && res_row_i >= 12'd2)
    else $error("result outside interior");

  a_frame_end_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_end_i |-> res_row_i == 12'd2)
    else $error("frame end on wrong row");

endmodule

bind grey_log5x5_filter_top glf_chk u_glf_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pix_ready_i  (pix_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_edge_i   (res_o.edge_value),
  .res_column_i (res_o.column),
  .res_row_i    (res_o.row),
  .res_end_i    (res_o.frame_end)
);

### tb/sv/testbench.sv
module testbench;
  import glf_pkg::*;

  localparam int unsigned RandomItems   = 1500;
  localparam int unsigned CalmItems     = 300;
  localparam int unsigned TallItems     = 200;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned SettleCycles  = 4;

  typedef struct packed {
    logic [7:0]  edge_value;
    logic [10:0] column;
    logic [11:0] row;
    logic        frame_end;
  } edge_beat_t;

  typedef enum logic {STEP_CFG, STEP_PIXEL} step_kind_e;

  typedef enum int {TEX_NOISE, TEX_FLAT, TEX_STARK} texture_e;

  typedef struct packed {
    step_kind_e            kind;
    logic [CfgIdxW-1:0]    reg_idx;
    logic [CfgDataW-1:0]   reg_val;
    pix_t                  red;
    pix_t                  green;
    pix_t                  blue;
    logic                  typed;
    edge_beat_t            want;
  } stim_row_t;

  localparam edge_beat_t NoBeat    = '0;
  localparam edge_beat_t CentreHit = '{8'd255, 11'd2, 12'd2, 1'b1};

  localparam stim_row_t WidthLow  =
    '{STEP_CFG, REG_WIDTH, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, NoBeat};
  localparam stim_row_t HeightLow =
    '{STEP_CFG, REG_HEIGHT, 12'd2, 8'd0, 8'd0, 8'd0, 1'b0, NoBeat};
  localparam stim_row_t Dark  =
    '{STEP_PIXEL, REG_WIDTH, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, NoBeat};
  localparam stim_row_t White =
    '{STEP_PIXEL, REG_WIDTH, 12'd0, 8'd255, 8'd255, 8'd255, 1'b0, NoBeat};
  localparam stim_row_t RedPx =
    '{STEP_PIXEL, REG_WIDTH, 12'd0, 8'd255, 8'd0, 8'd0, 1'b0, NoBeat};
  localparam stim_row_t GreenPx =
    '{STEP_PIXEL, REG_WIDTH, 12'd0, 8'd0, 8'd255, 8'd0, 1'b0, NoBeat};
  localparam stim_row_t BluePx =
    '{STEP_PIXEL, REG_WIDTH, 12'd0, 8'd0, 8'd0, 8'd255, 1'b0, NoBeat};
  localparam stim_row_t LastWhite =
    '{STEP_PIXEL, REG_WIDTH, 12'd0, 8'd255, 8'd255, 8'd255, 1'b1, CentreHit};

  // 5x5 frame: bright centre, primaries and white only where the kernel weight is zero
  localparam stim_row_t OpeningPlan [27] = '{
    WidthLow, HeightLow,
    RedPx, GreenPx, Dark, BluePx, White,
    White, Dark, Dark, Dark, White,
    Dark, Dark, White, Dark, Dark,
    White, Dark, Dark, Dark, White,
    White, White, Dark, White, LastWhite
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  glf_pix_if pix_if ();
  glf_res_if res_if ();

  grey_log5x5_filter_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  bit [7:0] grey_lines [LineBufs*MaxWidth];
  bit [7:0] win [5][5];
  int unsigned px_col;
  int unsigned px_row;
  logic [CfgDataW-1:0] width_reg;
  logic [CfgDataW-1:0] height_reg;

  edge_beat_t edge_due [$];
  edge_beat_t due_beat;

  int unsigned gap_rate;
  int unsigned stall_rate;
  int unsigned stall_left;
  bit calm;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  function automatic int unsigned eff_width();
    if (width_reg < MinSize) return MinSize;
    if (width_reg > MaxWidthW) return MaxWidth;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg < MinSize) ? MinSize : height_reg;
  endfunction

  function automatic int unsigned frame_left();
    int unsigned w, h, c, r;
    w = eff_width();
    h = eff_height();
    c = px_col;
    r = px_row;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) r = 0;
    return (h - 1 - r) * w + (w - c);
  endfunction

  function automatic bit filter_pixel(input pix_t r, input pix_t g, input pix_t b,
                                      output edge_beat_t beat);
    int unsigned w, h, grey, col, row;
    int acc;
    w = eff_width();
    h = eff_height();
    grey = (307 * int'(r) + 604 * int'(g) + 113 * int'(b)) >> 10;
    if (px_col >= w) begin
      px_col = 0;
      px_row++;
    end
    if (px_row >= h) px_row = 0;
    col = px_col;
    row = px_row;
    for (int y = 0; y < 5; y++)
      for (int x = 0; x < 4; x++) win[y][x] = win[y][x+1];
    for (int y = 0; y < 4; y++)
      win[y][4] = grey_lines[((row + LineBufs - (4 - y)) % LineBufs) * MaxWidth + col];
    win[4][4] = 8'(grey);
    grey_lines[(row % LineBufs) * MaxWidth + col] = 8'(grey);

    acc = 16 * int'(win[2][2])
        - int'(win[1][1]) - int'(win[1][3]) - int'(win[3][1]) - int'(win[3][3])
        - 2 * (int'(win[1][2]) + int'(win[2][1]) + int'(win[2][3]) + int'(win[3][2]))
        - int'(win[0][2]) - int'(win[2][0]) - int'(win[2][4]) - int'(win[4][2]);
    if (acc > 255) acc = 255;
    if (acc < 0) acc = 0;
    beat.edge_value = 8'(acc);
    beat.column     = 11'(col - 2);
    beat.row        = 12'(h + 1 - row);
    beat.frame_end  = (row == h - 1) && (col == w - 1);

    px_col = col + 1;
    if (px_col >= w) begin
      px_col = 0;
      px_row = row + 1;
      if (px_row >= h) px_row = 0;
    end
    return (row >= 4) && (col >= 4);
  endfunction

  function automatic pix_t shade(input texture_e tex, input pix_t base);
    int v;
    case (tex)
      TEX_FLAT: begin
        v = int'(base) + int'($urandom_range(0, 12)) - 6;
        return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : pix_t'(v);
      end
      TEX_STARK: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic send_pixel(input pix_t r, input pix_t g, input pix_t b,
                            input bit typed, input edge_beat_t want);
    edge_beat_t beat;
    bit produced;
    if (!calm && gap_rate != 0 && $urandom_range(0, gap_rate) == 0) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.red   <= r;
    pix_if.green <= g;
    pix_if.blue  <= b;
    do @(posedge clk_i); while (!pix_if.ready);
    produced = filter_pixel(r, g, b, beat);
    if (typed) edge_due.push_back(want);
    else if (produced) edge_due.push_back(beat);
    @(negedge clk_i);
  endtask

  task automatic stream_pixels(input int unsigned count, input texture_e tex);
    pix_t base;
    base = pix_t'($urandom_range(0, 255));
    repeat (count) send_pixel(shade(tex, base), shade(tex, base), shade(tex, base),
                              1'b0, NoBeat);
  endtask

  task automatic settle();
    pix_if.valid <= 1'b0;
    while (edge_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_WIDTH) width_reg = val;
    else height_reg = val;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (calm || stall_rate == 0) begin
      res_if.ready <= 1'b1;
    end else if (stall_left != 0) begin
      res_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, stall_rate) == 0) begin
      res_if.ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (edge_due.size() == 0) begin
        flag_mismatch("stray result beat, column", res_if.column, -1);
      end else begin
        due_beat = edge_due.pop_front();
        if (res_if.edge_value !== due_beat.edge_value)
          flag_mismatch("edge_value", res_if.edge_value, due_beat.edge_value);
        if (res_if.column !== due_beat.column)
          flag_mismatch("column", res_if.column, due_beat.column);
        if (res_if.row !== due_beat.row)
          flag_mismatch("row", res_if.row, due_beat.row);
        if (res_if.frame_end !== due_beat.frame_end)
          flag_mismatch("frame_end", res_if.frame_end, due_beat.frame_end);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no beat for %0d cycles", $time, WatchdogLimit);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned count;

    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    pix_if.valid = 1'b0;
    pix_if.red   = '0;
    pix_if.green = '0;
    pix_if.blue  = '0;
    res_if.ready = 1'b0;
    width_reg    = WidthReset;
    height_reg   = HeightReset;
    px_col       = 0;
    px_row       = 0;
    gap_rate     = 3;
    stall_rate   = 3;
    stall_left   = 0;
    calm         = 1'b0;
    mismatches   = 0;
    quiet_cycles = 0;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (OpeningPlan[i]) begin
      if (OpeningPlan[i].kind == STEP_CFG) begin
        settle();
        cfg_write(OpeningPlan[i].reg_idx, OpeningPlan[i].reg_val);
      end else begin
        send_pixel(OpeningPlan[i].red, OpeningPlan[i].green, OpeningPlan[i].blue,
                   OpeningPlan[i].typed, OpeningPlan[i].want);
      end
    end

    // fill every line store column the random frames read, then run a tall frame partway
    for (int k = 0; k < 2; k++) begin
      settle();
      gap_rate   = 4 * k;
      stall_rate = 4 * (1 - k) + 6;
      cfg_write(REG_WIDTH, (k == 0) ? 12'd16 : 12'd5);
      cfg_write(REG_HEIGHT, (k == 0) ? 12'd5 : 12'd4095);
      stream_pixels((k == 0) ? frame_left() : TallItems, texture_e'($urandom_range(0, 2)));
    end
    settle();
    cfg_write(REG_HEIGHT, 12'd12);

    sent = 0;
    while (sent < RandomItems) begin
      settle();
      calm = (sent + CalmItems >= RandomItems);
      gap_rate   = calm ? 0 : 4 * $urandom_range(0, 2);
      stall_rate = calm ? 0 : 4 * $urandom_range(0, 2);
      if ($urandom_range(0, 3) != 0)
        cfg_write(REG_WIDTH, ($urandom_range(0, 7) == 0) ?
                  CfgDataW'($urandom_range(0, 4)) : CfgDataW'($urandom_range(5, 16)));
      if ($urandom_range(0, 3) != 0)
        cfg_write(REG_HEIGHT, ($urandom_range(0, 7) == 0) ?
                  CfgDataW'($urandom_range(0, 4)) : CfgDataW'($urandom_range(5, 12)));
      count = frame_left();
      // stop partway so the next settings land mid-frame
      if (count > 1 && $urandom_range(0, 4) == 0) count = $urandom_range(1, count - 1);
      stream_pixels(count, texture_e'($urandom_range(0, 2)));
      sent += count;
    end

    settle();
    repeat (6) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
